### rtl/fgta_pkg.sv
package fgta_pkg;

    localparam int MAX_LOOPS = 8;
    localparam int LOOP_AW   = (MAX_LOOPS > 1) ? $clog2(MAX_LOOPS) : 1;
    localparam int CNT_W     = $clog2(MAX_LOOPS + 1);
    localparam int CMP_W     = (CNT_W > 4) ? CNT_W : 4;

    localparam int IDX_W     = 3;
    localparam int TGT_W     = 16;
    localparam int REF_W     = 32;
    localparam int ACT_W     = 4;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 1;

    localparam int DIV_NUM_W  = 32;
    localparam int DIV_DEN_W  = 16;
    localparam int DIV_STEP   = 2;
    localparam int DIV_CYCLES = DIV_NUM_W / DIV_STEP;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    // floor(x / 100) == (x * 10737419) >> 30 for every x below 2**23,
    // which covers target * 97.
    localparam int RCP_W      = 24;
    localparam int RCP_SHIFT  = 30;
    localparam int RCP_PROD_W = DIV_NUM_W + RCP_W;

    localparam logic signed [REF_W-1:0] REF_FLOOR  = -32'sd10000;
    localparam logic [DIV_DEN_W-1:0]    INTAKE_NUM = 16'd97;
    localparam logic [DIV_DEN_W-1:0]    INTAKE_DEN = 16'd100;
    localparam logic [RCP_W-1:0]        INTAKE_RCP = 24'd10737419;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_MUL_I,
        S_RCP_I,
        S_MUL_P,
        S_DIVS_P,
        S_DIVW_P,
        S_OUT
    } t_state;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_LOOPS,
        CFG_MAX_DECREASE,
        CFG_INTAKE_MIN,
        CFG_INTAKE_MAX,
        CFG_EXHAUST_MIN,
        CFG_EXHAUST_MAX,
        CFG_PUMP_MIN,
        CFG_PUMP_MAX
    } t_cfg_idx;

    typedef struct packed {
        logic                    en;
        logic [LOOP_AW-1:0]      addr;
        logic [TGT_W-1:0]        target;
        logic signed [REF_W-1:0] reference;
    } t_tbl_wr;

    typedef struct packed {
        logic                    submitted;
        logic [TGT_W-1:0]        target;
        logic signed [REF_W-1:0] reference;
    } t_tbl_rd;

    function automatic logic [TGT_W-1:0] clamp_drive(
        input logic [DIV_NUM_W-1:0] v,
        input logic [TGT_W-1:0]     lo,
        input logic [TGT_W-1:0]     hi
    );
        logic [DIV_NUM_W-1:0] t;
        t = v;
        if (t < DIV_NUM_W'(lo)) begin
            t = DIV_NUM_W'(lo);
        end
        if (t > DIV_NUM_W'(hi)) begin
            t = DIV_NUM_W'(hi);
        end
        return t[TGT_W-1:0];
    endfunction

endpackage

### rtl/fgta_div.sv
module fgta_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [fgta_pkg::DIV_NUM_W-1:0]     i_dividend,
    input  logic [fgta_pkg::DIV_DEN_W-1:0]     i_divisor,
    output logic                               o_busy,
    output logic                               o_done,
    output logic [fgta_pkg::DIV_NUM_W-1:0]     o_quot
);

    logic                               r_busy;
    logic                               r_done;
    logic [fgta_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [fgta_pkg::DIV_DEN_W-1:0]     r_rem;
    logic [fgta_pkg::DIV_NUM_W-1:0]     r_quo;
    logic [fgta_pkg::DIV_DEN_W-1:0]     r_den;
    logic [fgta_pkg::DIV_DEN_W-1:0]     n_rem;
    logic [fgta_pkg::DIV_NUM_W-1:0]     n_quo;

    // Restoring division, two quotient bits per cycle.
    always_comb begin
        logic [fgta_pkg::DIV_DEN_W:0]   sh;
        logic [fgta_pkg::DIV_DEN_W-1:0] rem;
        logic [fgta_pkg::DIV_NUM_W-1:0] quo;
        rem = r_rem;
        quo = r_quo;
        for (int k = 0; k < fgta_pkg::DIV_STEP; k++) begin
            sh  = {rem, quo[fgta_pkg::DIV_NUM_W-1]};
            quo = {quo[fgta_pkg::DIV_NUM_W-2:0], 1'b0};
            if (sh >= {1'b0, r_den}) begin
                sh     = sh - {1'b0, r_den};
                quo[0] = 1'b1;
            end
            rem = sh[fgta_pkg::DIV_DEN_W-1:0];
        end
        n_rem = rem;
        n_quo = quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_den  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == fgta_pkg::DIV_CNT_W'(fgta_pkg::DIV_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

### rtl/fgta_table.sv
module fgta_table (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fgta_pkg::t_tbl_wr              i_wr,
    input  logic                           i_clear,
    input  logic [fgta_pkg::LOOP_AW-1:0]   i_rd_addr,
    output fgta_pkg::t_tbl_rd              o_rd
);

    logic [fgta_pkg::MAX_LOOPS-1:0]    r_sub;
    logic [fgta_pkg::TGT_W-1:0]        r_tgt [fgta_pkg::MAX_LOOPS];
    logic signed [fgta_pkg::REF_W-1:0] r_ref [fgta_pkg::MAX_LOOPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= '0;
        end else if (i_clear) begin
            r_sub <= '0;
        end else if (i_wr.en) begin
            r_sub[i_wr.addr] <= 1'b1;
        end
    end

    // Entries are read only while their flag is set, so no reset.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_tgt[i_wr.addr] <= i_wr.target;
            r_ref[i_wr.addr] <= i_wr.reference;
        end
    end

    assign o_rd.submitted = r_sub[i_rd_addr];
    assign o_rd.target    = r_tgt[i_rd_addr];
    assign o_rd.reference = r_ref[i_rd_addr];

endmodule

### rtl/fan_group_target_arbiter.sv
// Channel  | Dir | Handshake              | Payload
// s        | in  | i_s_tvalid/o_s_tready  | i_s_tdata: loop_index, target, reference
// m        | out | o_m_tvalid/i_m_tready  | o_m_tdata: drives and owner; o_m_tuser: decided
// cfg      | in  | i_cfg_we               | i_cfg_idx, i_cfg_wdata
//
// Each accepted request runs the reference scan over the active loops, a decide step,
// two multiply steps for intake 97/100, a pump multiply, then one divider run for pump
// scaling before the result goes to the output register; the next request is taken
// only after that. Without an owner after the decide step the arithmetic is skipped.
// Reset is synchronous and active low; it clears all submitted flags and the owner.
// o_s_tready is high only while the sequencer is idle; a result waiting in the output
// register holds the sequencer in its last step until the output side drains.
module fan_group_target_arbiter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [2:0] loop_index, [18:3] target_value, [50:19] priority_reference
    input  logic [fgta_pkg::S_TDATA_W-1:0]     i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [15:0] chosen_target, [18:16] winner_index, [34:19] intake_drive,
    // [50:35] exhaust_drive, [66:51] pump_drive
    output logic [fgta_pkg::M_TDATA_W-1:0]     o_m_tdata,
    // [0] decided
    output logic [fgta_pkg::M_TUSER_W-1:0]     o_m_tuser,
    input  logic                               i_cfg_we,
    input  logic [fgta_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fgta_pkg::CFG_W-1:0]         i_cfg_wdata
);

    fgta_pkg::t_state r_state, n_state;

    logic [fgta_pkg::ACT_W-1:0]        r_active;
    logic [fgta_pkg::TGT_W-1:0]        r_max_dec;
    logic [fgta_pkg::TGT_W-1:0]        r_int_min, r_int_max;
    logic [fgta_pkg::TGT_W-1:0]        r_exh_min, r_exh_max;
    logic [fgta_pkg::TGT_W-1:0]        r_pump_min, r_pump_max;

    logic [fgta_pkg::CNT_W-1:0]        r_scan;
    logic signed [fgta_pkg::REF_W-1:0] r_best_ref;
    logic [fgta_pkg::TGT_W-1:0]        r_best_tgt;
    logic [fgta_pkg::IDX_W-1:0]        r_best_idx;
    logic                              r_have_win;
    logic                              r_all_in;
    logic                              r_decided;

    logic [fgta_pkg::TGT_W-1:0]        r_cur;
    logic                              r_owner_valid;
    logic [fgta_pkg::IDX_W-1:0]        r_owner;

    logic [fgta_pkg::DIV_NUM_W-1:0]    r_prod;
    logic [fgta_pkg::TGT_W-1:0]        r_q_i;
    logic [fgta_pkg::DIV_NUM_W-1:0]    r_q_p;

    logic                              r_m_valid;
    logic [fgta_pkg::M_TDATA_W-1:0]    r_m_data;
    logic [fgta_pkg::M_TUSER_W-1:0]    r_m_user;

    logic                              w_s_acc;
    logic [fgta_pkg::IDX_W-1:0]        w_idx;
    logic [fgta_pkg::CMP_W-1:0]        w_count;
    logic                              w_scan_end;
    logic                              w_win;
    logic [fgta_pkg::TGT_W:0]          w_drop;
    logic [fgta_pkg::TGT_W-1:0]        w_limited;
    logic                              w_clear;
    logic                              w_out_load;
    logic                              w_div_start;
    logic [fgta_pkg::DIV_DEN_W-1:0]    w_div_den;
    logic                              w_div_busy;
    logic                              w_div_done;
    logic [fgta_pkg::DIV_NUM_W-1:0]    w_div_quot;
    logic [fgta_pkg::RCP_PROD_W-1:0]   w_rcp_prod;
    logic [fgta_pkg::DIV_NUM_W-1:0]    w_pump_raw;
    logic [fgta_pkg::TGT_W-1:0]        w_intake, w_exhaust, w_pump;
    fgta_pkg::t_tbl_wr                 w_wr;
    fgta_pkg::t_tbl_rd                 w_rd;

    assign o_s_tready = (r_state == fgta_pkg::S_IDLE);
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_idx      = i_s_tdata[2:0];

    assign w_count = (fgta_pkg::CMP_W'(r_active) > fgta_pkg::CMP_W'(fgta_pkg::MAX_LOOPS))
                   ? fgta_pkg::CMP_W'(fgta_pkg::MAX_LOOPS) : fgta_pkg::CMP_W'(r_active);

    // Drop requests from loops outside the active range.
    assign w_wr.en        = w_s_acc && (fgta_pkg::CMP_W'(w_idx) < w_count);
    assign w_wr.addr      = fgta_pkg::LOOP_AW'(w_idx);
    assign w_wr.target    = i_s_tdata[18:3];
    assign w_wr.reference = $signed(i_s_tdata[50:19]);

    fgta_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_clear   (w_clear),
        .i_rd_addr (r_scan[fgta_pkg::LOOP_AW-1:0]),
        .o_rd      (w_rd)
    );

    fgta_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_prod),
        .i_divisor  (w_div_den),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    assign w_scan_end = (fgta_pkg::CMP_W'(r_scan) == w_count);
    assign w_win      = r_have_win && r_all_in;
    assign w_drop     = {1'b0, r_cur} - {1'b0, r_best_tgt};
    assign w_limited  = ((r_best_tgt < r_cur) && (w_drop > {1'b0, r_max_dec}))
                      ? (r_cur - r_max_dec) : r_best_tgt;

    // Divide target * 97 by 100 through the reciprocal.
    assign w_rcp_prod = fgta_pkg::RCP_PROD_W'(r_prod)
                      * fgta_pkg::RCP_PROD_W'(fgta_pkg::INTAKE_RCP);

    assign w_pump_raw = (r_exh_max == '0) ? fgta_pkg::DIV_NUM_W'(r_pump_max) : r_q_p;
    assign w_intake   = r_owner_valid
                      ? fgta_pkg::clamp_drive(fgta_pkg::DIV_NUM_W'(r_q_i), r_int_min, r_int_max)
                      : '0;
    assign w_exhaust  = r_owner_valid
                      ? fgta_pkg::clamp_drive(fgta_pkg::DIV_NUM_W'(r_cur), r_exh_min, r_exh_max)
                      : '0;
    assign w_pump     = r_owner_valid
                      ? fgta_pkg::clamp_drive(w_pump_raw, r_pump_min, r_pump_max)
                      : '0;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fgta_pkg::S_IDLE: begin
                if (w_s_acc) begin
                    n_state = fgta_pkg::S_SCAN;
                end
            end
            fgta_pkg::S_SCAN: begin
                if (w_scan_end) begin
                    n_state = fgta_pkg::S_DECIDE;
                end
            end
            fgta_pkg::S_DECIDE: begin
                n_state = fgta_pkg::S_MUL_I;
            end
            fgta_pkg::S_MUL_I: begin
                n_state = r_owner_valid ? fgta_pkg::S_RCP_I : fgta_pkg::S_OUT;
            end
            fgta_pkg::S_RCP_I: begin
                n_state = fgta_pkg::S_MUL_P;
            end
            fgta_pkg::S_MUL_P: begin
                n_state = fgta_pkg::S_DIVS_P;
            end
            fgta_pkg::S_DIVS_P: begin
                n_state = fgta_pkg::S_DIVW_P;
            end
            fgta_pkg::S_DIVW_P: begin
                if (w_div_done) begin
                    n_state = fgta_pkg::S_OUT;
                end
            end
            fgta_pkg::S_OUT: begin
                if (w_out_load) begin
                    n_state = fgta_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fgta_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        w_clear     = 1'b0;
        w_div_start = 1'b0;
        w_div_den   = r_exh_max;
        w_out_load  = 1'b0;
        unique case (r_state)
            fgta_pkg::S_DECIDE: begin
                w_clear = w_win;
            end
            fgta_pkg::S_DIVS_P: begin
                w_div_start = 1'b1;
            end
            fgta_pkg::S_OUT: begin
                w_out_load = !r_m_valid || i_m_tready;
            end
            default: begin
                w_clear = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fgta_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= '0;
            r_max_dec  <= '1;
            r_int_min  <= '0;
            r_int_max  <= '1;
            r_exh_min  <= '0;
            r_exh_max  <= '1;
            r_pump_min <= '0;
            r_pump_max <= '1;
        end else if (i_cfg_we) begin
            unique case (fgta_pkg::t_cfg_idx'(i_cfg_idx))
                fgta_pkg::CFG_ACTIVE_LOOPS: r_active   <= i_cfg_wdata[fgta_pkg::ACT_W-1:0];
                fgta_pkg::CFG_MAX_DECREASE: r_max_dec  <= i_cfg_wdata;
                fgta_pkg::CFG_INTAKE_MIN:   r_int_min  <= i_cfg_wdata;
                fgta_pkg::CFG_INTAKE_MAX:   r_int_max  <= i_cfg_wdata;
                fgta_pkg::CFG_EXHAUST_MIN:  r_exh_min  <= i_cfg_wdata;
                fgta_pkg::CFG_EXHAUST_MAX:  r_exh_max  <= i_cfg_wdata;
                fgta_pkg::CFG_PUMP_MIN:     r_pump_min <= i_cfg_wdata;
                fgta_pkg::CFG_PUMP_MAX:     r_pump_max <= i_cfg_wdata;
            endcase
        end
    end

    // Owner state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur         <= '0;
            r_owner_valid <= 1'b0;
            r_owner       <= '0;
        end else if (w_clear) begin
            r_cur         <= w_limited;
            r_owner_valid <= 1'b1;
            r_owner       <= r_best_idx;
        end
    end

    // Scan and arithmetic datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan     <= '0;
            r_have_win <= 1'b0;
            r_all_in   <= 1'b1;
            r_decided  <= 1'b0;
        end else begin
            unique case (r_state)
                fgta_pkg::S_IDLE: begin
                    r_scan     <= '0;
                    r_best_ref <= fgta_pkg::REF_FLOOR;
                    r_have_win <= 1'b0;
                    r_all_in   <= 1'b1;
                    r_decided  <= 1'b0;
                end
                fgta_pkg::S_SCAN: begin
                    if (!w_scan_end) begin
                        r_scan <= r_scan + 1'b1;
                        if (w_rd.submitted) begin
                            if (w_rd.reference > r_best_ref) begin
                                r_best_ref <= w_rd.reference;
                                r_best_tgt <= w_rd.target;
                                r_best_idx <= fgta_pkg::IDX_W'(r_scan);
                                r_have_win <= 1'b1;
                            end
                        end else begin
                            r_all_in <= 1'b0;
                        end
                    end
                end
                fgta_pkg::S_DECIDE: begin
                    r_decided <= w_win;
                end
                fgta_pkg::S_MUL_I: begin
                    r_prod <= fgta_pkg::DIV_NUM_W'(r_cur)
                            * fgta_pkg::DIV_NUM_W'(fgta_pkg::INTAKE_NUM);
                end
                fgta_pkg::S_RCP_I: begin
                    r_q_i <= w_rcp_prod[fgta_pkg::RCP_SHIFT +: fgta_pkg::TGT_W];
                end
                fgta_pkg::S_MUL_P: begin
                    r_prod <= fgta_pkg::DIV_NUM_W'(r_cur) * fgta_pkg::DIV_NUM_W'(r_pump_max);
                end
                fgta_pkg::S_DIVW_P: begin
                    if (w_div_done) begin
                        r_q_p <= w_div_quot;
                    end
                end
                default: begin
                    r_decided <= r_decided;
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_user <= r_decided;
            r_m_data <= {5'd0, w_pump, w_exhaust, w_intake, r_owner, r_cur};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider started while busy");

    a_accept_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> (r_state == fgta_pkg::S_SCAN))
        else $error("accepted request did not start a scan");

    a_decided_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> r_owner_valid)
        else $error("decision reported without an owner");

    a_exhaust_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[50:35] <= r_exh_max))
        else $error("exhaust drive above its limit");

endmodule

### verif/fan_group_target_arbiter_test.sv
module fan_group_target_arbiter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fgta_pkg::*;

    localparam int STALL_LIMIT    = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASES         = 6;
    localparam int PHASE_REQUESTS = 330;
    localparam int DRAIN_CYCLES   = 60;

    typedef struct packed {
        logic             decided;
        logic [TGT_W-1:0] chosen;
        logic [IDX_W-1:0] winner;
        logic [TGT_W-1:0] intake;
        logic [TGT_W-1:0] exhaust;
        logic [TGT_W-1:0] pump;
    } fan_drive_t;

    typedef struct {
        bit                      is_write;
        t_cfg_idx                reg_sel;
        logic [CFG_W-1:0]        reg_val;
        logic [IDX_W-1:0]        loop;
        logic [TGT_W-1:0]        target;
        logic signed [REF_W-1:0] prio;
        bit                      typed;
        fan_drive_t              want;
    } plan_row_t;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    // [2:0] loop_index, [18:3] target_value, [50:19] priority_reference
    logic [S_TDATA_W-1:0]   i_s_tdata   = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    // [15:0] chosen_target, [18:16] winner_index, [34:19] intake_drive,
    // [50:35] exhaust_drive, [66:51] pump_drive
    logic [M_TDATA_W-1:0]   o_m_tdata;
    // [0] decided
    logic [M_TUSER_W-1:0]   o_m_tuser;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx   = '0;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;

    // predictor copy of registers and arbitration state
    logic [CFG_W-1:0]        limit_regs [2**CFG_IDX_W];
    bit                      loop_in    [MAX_LOOPS];
    logic [TGT_W-1:0]        loop_tgt   [MAX_LOOPS];
    logic signed [REF_W-1:0] loop_prio  [MAX_LOOPS];
    logic [TGT_W-1:0]        group_target;
    bit                      owned;
    logic [IDX_W-1:0]        owner;

    fan_drive_t pending_drives [$];
    int         mismatch_count = 0;
    int         stuck_cycles   = 0;
    int         src_idle_pct   = 33;
    int         rx_idle_pct    = 53;
    logic       rx_hold_req    = 1'b0;
    int         rx_hold_left   = 0;

    fan_group_target_arbiter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [TGT_W-1:0] clamp_limits(
        input longint unsigned  v,
        input logic [TGT_W-1:0] lo,
        input logic [TGT_W-1:0] hi
    );
        if (v < lo) begin
            v = lo;
        end
        if (v > hi) begin
            v = hi;
        end
        return TGT_W'(v);
    endfunction

    function automatic fan_drive_t arbitrate(
        input logic [IDX_W-1:0]        loop,
        input logic [TGT_W-1:0]        target,
        input logic signed [REF_W-1:0] prio
    );
        int                      count;
        bit                      all_in;
        bit                      found;
        logic signed [REF_W-1:0] best_prio;
        logic [TGT_W-1:0]        best_tgt;
        logic [IDX_W-1:0]        best_loop;
        longint unsigned         t;
        longint unsigned         pump;
        fan_drive_t              r;
        count = limit_regs[CFG_ACTIVE_LOOPS][ACT_W-1:0];
        if (count > MAX_LOOPS) begin
            count = MAX_LOOPS;
        end
        all_in    = 1'b1;
        found     = 1'b0;
        best_prio = REF_FLOOR;
        best_tgt  = '0;
        best_loop = '0;
        r         = '0;
        // requests from inactive loops are dropped, but the scan still runs
        if (int'(loop) < count) begin
            loop_in[loop]   = 1'b1;
            loop_tgt[loop]  = target;
            loop_prio[loop] = prio;
        end
        for (int i = 0; i < count; i++) begin
            if (!loop_in[i]) begin
                all_in = 1'b0;
            end else if (loop_prio[i] > best_prio) begin
                best_prio = loop_prio[i];
                best_tgt  = loop_tgt[i];
                best_loop = IDX_W'(i);
                found     = 1'b1;
            end
        end
        if (found && all_in) begin
            if (best_tgt < group_target &&
                group_target - best_tgt > limit_regs[CFG_MAX_DECREASE]) begin
                best_tgt = group_target - limit_regs[CFG_MAX_DECREASE];
            end
            group_target = best_tgt;
            owner        = best_loop;
            owned        = 1'b1;
            foreach (loop_in[i]) begin
                loop_in[i] = 1'b0;
            end
            r.decided = 1'b1;
        end
        r.chosen = group_target;
        r.winner = owner;
        if (owned) begin
            t = group_target;
            r.intake  = clamp_limits(t * INTAKE_NUM / INTAKE_DEN,
                                     limit_regs[CFG_INTAKE_MIN], limit_regs[CFG_INTAKE_MAX]);
            r.exhaust = clamp_limits(t, limit_regs[CFG_EXHAUST_MIN],
                                     limit_regs[CFG_EXHAUST_MAX]);
            if (limit_regs[CFG_EXHAUST_MAX] == 0) begin
                pump = limit_regs[CFG_PUMP_MAX];
            end else begin
                pump = t * limit_regs[CFG_PUMP_MAX] / limit_regs[CFG_EXHAUST_MAX];
            end
            r.pump = clamp_limits(pump, limit_regs[CFG_PUMP_MIN], limit_regs[CFG_PUMP_MAX]);
        end
        return r;
    endfunction

    function automatic string drive_text(input fan_drive_t d);
        return $sformatf("decided=%0d target=%0d winner=%0d intake=%0d exhaust=%0d pump=%0d",
                         d.decided, d.chosen, d.winner, d.intake, d.exhaust, d.pump);
    endfunction

    function automatic plan_row_t reg_row(input t_cfg_idx sel, input logic [CFG_W-1:0] val);
        plan_row_t r;
        r.is_write = 1'b1;
        r.reg_sel  = sel;
        r.reg_val  = val;
        r.typed    = 1'b0;
        return r;
    endfunction

    function automatic plan_row_t req_row(
        input logic [IDX_W-1:0]        loop,
        input logic [TGT_W-1:0]        target,
        input logic signed [REF_W-1:0] prio
    );
        plan_row_t r;
        r.is_write = 1'b0;
        r.reg_sel  = CFG_ACTIVE_LOOPS;
        r.loop     = loop;
        r.target   = target;
        r.prio     = prio;
        r.typed    = 1'b0;
        r.want     = '0;
        return r;
    endfunction

    function automatic plan_row_t checked_row(
        input logic [IDX_W-1:0]        loop,
        input logic [TGT_W-1:0]        target,
        input logic signed [REF_W-1:0] prio,
        input fan_drive_t              want
    );
        plan_row_t r;
        r       = req_row(loop, target, prio);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic logic [TGT_W-1:0] rand_target();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return TGT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic signed [REF_W-1:0] rand_prio();
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return REF_FLOOR;
            2:       return REF_FLOOR + 1;
            3:       return REF_W'($urandom_range(0, 3));
            default: return int'($urandom_range(0, 200000)) - 100000;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_reg(
        input logic [CFG_W-1:0] a,
        input logic [CFG_W-1:0] b,
        input int               lo,
        input int               hi
    );
        case ($urandom_range(0, 7))
            0:       return a;
            1:       return b;
            default: return CFG_W'($urandom_range(lo, hi));
        endcase
    endfunction

    task automatic send_request(
        input logic [IDX_W-1:0]        loop,
        input logic [TGT_W-1:0]        target,
        input logic signed [REF_W-1:0] prio,
        input bit                      typed,
        input fan_drive_t              want
    );
        fan_drive_t r;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= S_TDATA_W'({prio, target, loop});
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        r = arbitrate(loop, target, prio);
        pending_drives.push_back(typed ? want : r);
    endtask

    // registers change only with the block idle and nothing outstanding
    task automatic write_reg(input t_cfg_idx sel, input logic [CFG_W-1:0] val);
        i_s_tvalid <= 1'b0;
        while (pending_drives.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= sel;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        limit_regs[sel] = val;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input int phase);
        int order [MAX_LOOPS];
        int active;
        int count;
        int sent;
        int last;
        int j;
        int tmp;
        src_idle_pct = (phase / 2 == 0) ? 33 : (phase / 2 == 1) ? 53 : 0;
        rx_idle_pct  = (phase / 2 == 0) ? 53 : (phase / 2 == 1) ? 33 : 0;
        case (phase)
            0:       active = MAX_LOOPS;
            1:       active = 15;
            2:       active = 1;
            default: active = $urandom_range(1, MAX_LOOPS);
        endcase
        write_reg(CFG_ACTIVE_LOOPS, CFG_W'(active));
        write_reg(CFG_MAX_DECREASE, pick_reg(16'd0, 16'hFFFF, 0, 4000));
        write_reg(CFG_INTAKE_MIN, pick_reg(16'd0, 16'hFFFF, 0, 20000));
        write_reg(CFG_INTAKE_MAX, pick_reg(16'hFFFF, 16'd0, 30000, 65535));
        write_reg(CFG_EXHAUST_MIN, pick_reg(16'd0, 16'hFFFF, 0, 20000));
        write_reg(CFG_EXHAUST_MAX, pick_reg(16'hFFFF, 16'd0, 30000, 65535));
        write_reg(CFG_PUMP_MIN, pick_reg(16'd0, 16'hFFFF, 0, 20000));
        write_reg(CFG_PUMP_MAX, pick_reg(16'hFFFF, 16'd0, 30000, 65535));
        // stall the result side so the block backs up into its input
        if (phase == 0) begin
            rx_hold_req = 1'b1;
        end
        count = (active > MAX_LOOPS) ? MAX_LOOPS : active;
        sent  = 0;
        while (sent < PHASE_REQUESTS) begin
            for (int k = 0; k < count; k++) begin
                order[k] = k;
            end
            for (int k = count - 1; k > 0; k--) begin
                j        = $urandom_range(0, k);
                tmp      = order[k];
                order[k] = order[j];
                order[j] = tmp;
            end
            // now and then cut a round short
            last = ($urandom_range(0, 7) == 0) ? $urandom_range(0, count - 1) : count - 1;
            for (int k = 0; k <= last; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_request(IDX_W'($urandom_range(0, MAX_LOOPS - 1)), rand_target(),
                                 rand_prio(), 1'b0, '0);
                end
                send_request(IDX_W'(order[k]), rand_target(), rand_prio(), 1'b0, '0);
                sent++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left = rx_hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (rx_hold_req) begin
            rx_hold_req  = 1'b0;
            rx_hold_left = HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        fan_drive_t got;
        fan_drive_t want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got = '{o_m_tuser[0], o_m_tdata[15:0], o_m_tdata[18:16], o_m_tdata[34:19],
                        o_m_tdata[50:35], o_m_tdata[66:51]};
                if (pending_drives.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected result: %s", drive_text(got));
                    end
                end else begin
                    want = pending_drives.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch: expected %s", drive_text(want));
                            $display("          actual   %s", drive_text(got));
                        end
                    end
                end
            end
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles = stuck_cycles + 1;
            end
            if (stuck_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin : stimulus
        plan_row_t plan [$];
        foreach (limit_regs[i]) begin
            limit_regs[i] = '0;
        end
        limit_regs[CFG_MAX_DECREASE] = '1;
        limit_regs[CFG_INTAKE_MAX]   = '1;
        limit_regs[CFG_EXHAUST_MAX]  = '1;
        limit_regs[CFG_PUMP_MAX]     = '1;
        foreach (loop_in[i]) begin
            loop_in[i] = 1'b0;
        end
        group_target = '0;
        owned        = 1'b0;
        owner        = '0;

        // no loops active and no owner: nothing decides, drives stay zero
        plan.push_back(checked_row(3'd3, 16'd1234, 32'sd5, '{1'b0, 16'd0, 3'd0, 16'd0, 16'd0, 16'd0}));
        plan.push_back(reg_row(CFG_ACTIVE_LOOPS, 16'd1));
        plan.push_back(checked_row(3'd0, 16'hFFFF, 32'sh7FFFFFFF,
                                   '{1'b1, 16'd65535, 3'd0, 16'd63568, 16'd65535, 16'd65535}));
        plan.push_back(checked_row(3'd0, 16'd0, -32'sd9999,
                                   '{1'b1, 16'd0, 3'd0, 16'd0, 16'd0, 16'd0}));
        // references at or below the floor never win; the flag stays set
        plan.push_back(checked_row(3'd0, 16'd500, -32'sd10000,
                                   '{1'b0, 16'd0, 3'd0, 16'd0, 16'd0, 16'd0}));
        plan.push_back(checked_row(3'd0, 16'd600, 32'sh80000000,
                                   '{1'b0, 16'd0, 3'd0, 16'd0, 16'd0, 16'd0}));
        plan.push_back(checked_row(3'd5, 16'd777, 32'sd100,
                                   '{1'b0, 16'd0, 3'd0, 16'd0, 16'd0, 16'd0}));
        plan.push_back(req_row(3'd0, 16'd40000, 32'sd0));
        plan.push_back(reg_row(CFG_ACTIVE_LOOPS, 16'd3));
        plan.push_back(reg_row(CFG_MAX_DECREASE, 16'd1000));
        // tie on the best reference goes to the lowest loop
        plan.push_back(req_row(3'd2, 16'd100, 32'sd50));
        plan.push_back(req_row(3'd0, 16'd200, 32'sd50));
        plan.push_back(req_row(3'd1, 16'd300, 32'sd10));
        // loop count past the table size scans every loop
        plan.push_back(reg_row(CFG_ACTIVE_LOOPS, 16'd12));
        for (int i = MAX_LOOPS - 1; i >= 0; i--) begin
            plan.push_back(req_row(IDX_W'(i), TGT_W'(i * 9000 + 7),
                                   (i == 4) ? 32'sd70000 : REF_W'(-10000 + i)));
        end
        // inverted limits, zero exhaust full scale, no decrease allowed
        plan.push_back(reg_row(CFG_MAX_DECREASE, 16'd0));
        plan.push_back(reg_row(CFG_INTAKE_MIN, 16'd60000));
        plan.push_back(reg_row(CFG_INTAKE_MAX, 16'd100));
        plan.push_back(reg_row(CFG_EXHAUST_MIN, 16'hFFFF));
        plan.push_back(reg_row(CFG_EXHAUST_MAX, 16'd0));
        plan.push_back(reg_row(CFG_PUMP_MIN, 16'd500));
        plan.push_back(reg_row(CFG_PUMP_MAX, 16'd200));
        plan.push_back(reg_row(CFG_ACTIVE_LOOPS, 16'd1));
        plan.push_back(checked_row(3'd0, 16'hFFFF, 32'sd1,
                                   '{1'b1, 16'd65535, 3'd0, 16'd100, 16'd0, 16'd200}));
        plan.push_back(checked_row(3'd0, 16'd0, 32'sd1,
                                   '{1'b1, 16'd65535, 3'd0, 16'd100, 16'd0, 16'd200}));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[n]) begin
            if (plan[n].is_write) begin
                write_reg(plan[n].reg_sel, plan[n].reg_val);
            end else begin
                send_request(plan[n].loop, plan[n].target, plan[n].prio,
                             plan[n].typed, plan[n].want);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            run_phase(phase);
        end

        i_s_tvalid <= 1'b0;
        while (pending_drives.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
